@@ rtl/core/mrms_pkg.sv @@
// ----------------------------------------------------------------------------
// mrms_pkg - shared definitions for the multichannel RMS current meter
// Default sizes, fixed field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package mrms_pkg;

	// Default sizes of the core.
	localparam int ADC_BITS_DEF   = 10;
	localparam int CHANNELS_DEF   = 4;
	localparam int MAX_WINDOW_DEF = 4096;

	// Fraction bits of the offset filter; the filter divides by 2**FILT_SHIFT.
	localparam int FILT_SHIFT = 10;

	// Fixed field widths.
	localparam int CHAN_W         = 2;
	localparam int SAMPLE_COUNT_W = 13;
	localparam int GAIN_W         = 16;
	localparam int RMS_W          = 26;
	localparam int CFG_DATA_W     = 16;
	localparam int CFG_IDX_W      = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 1'd1;

	// Register reset values.
	localparam logic [SAMPLE_COUNT_W-1:0] SAMPLE_COUNT_RST = 13'd400;
	localparam logic [GAIN_W-1:0]         GAIN_RST         = 16'd4834;

endpackage

@@ rtl/core/multichannel_rms_current_meter_core.sv @@
// ----------------------------------------------------------------------------
// multichannel_rms_current_meter_core - RMS current meter with DC removal
// Per-channel DC offset tracking, windowed sum of squares and a bit-serial
// divide, square root and gain multiply at the end of each window.
// ----------------------------------------------------------------------------
// Usage. Each request on the slave stream carries one raw ADC sample in
// s_tdata and its channel number in s_tuser. The channel's DC offset filter
// is updated, the offset is removed and the square of the remainder is added
// to the running window sum. When the window of sample_count samples is
// complete, one result request leaves on the master stream: the RMS current
// in milliamps in m_tdata and the channel of the closing sample in m_tuser.
// Samples that do not close a window give no result.
// The squaring, the divide, the square root and the gain multiply all run
// one bit (or one bit pair) per cycle, each in its own sequencer state.
// A sample occupies the core through the filter update, the magnitude, the
// squarer and the accumulate step; s_tready is high only while the core is
// idle. A window-closing sample goes on through the long divide, the square
// root and the gain multiply before its result is registered on the master
// side. The result sits in an output register: if the receiver stalls, the
// core still takes ordinary samples, and only a second finished result waits.
// Reset clears the window, sets every offset to mid-scale and loads the
// default window length (400) and gain (4834). Configuration is written
// through cfg_we/cfg_index/cfg_data; the user must write it only while no
// sample is in flight, as the core itself does not enforce this.
// ----------------------------------------------------------------------------
module multichannel_rms_current_meter_core
	import mrms_pkg::*;
#(
	parameter int ADC_BITS   = ADC_BITS_DEF,
	parameter int CHANNELS   = CHANNELS_DEF,
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Slave stream: one sample request.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((ADC_BITS+7)/8)*8-1:0]     s_tdata,   // [ADC_BITS-1:0] sample
	input  logic [CHAN_W-1:0]                 s_tuser,   // [1:0] channel
	// Master stream: one result request per completed window.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [((RMS_W+7)/8)*8-1:0]        m_tdata,   // [25:0] rms_ma
	output logic [CHAN_W-1:0]                 m_tuser,   // [1:0] window_channel
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [CFG_IDX_W-1:0]              cfg_index,
	input  logic [CFG_DATA_W-1:0]             cfg_data
);

	// Widths derived from the parameters.
	localparam int VW      = ADC_BITS + FILT_SHIFT;       // offset, magnitude
	localparam int DW      = VW + 1;                      // signed difference
	localparam int SQ_W    = 2 * VW;                      // one square
	localparam int SEEN_W  = $clog2(MAX_WINDOW + 1);      // sample counter
	localparam int SUM_W   = SQ_W + SEEN_W;               // window sum
	localparam int RX_W    = SUM_W + (SUM_W % 2);         // root operand, even
	localparam int ROOT_W  = RX_W / 2;
	localparam int SR_W    = ROOT_W + 1;                  // root remainder
	localparam int PROD_W  = GAIN_W + ROOT_W;             // gain product
	localparam int CNT_W   = $clog2(SUM_W);
	localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CMP_W   = (SEEN_W > SAMPLE_COUNT_W) ? SEEN_W : SAMPLE_COUNT_W;
	localparam int TAGS    = 2 ** CHAN_W;
	localparam int OUT_W   = ((RMS_W + 7) / 8) * 8;

	localparam logic [VW-1:0] OFFSET_RST = VW'(1) << (VW - 1);

	// Sequencer states.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FILT = 4'd1;
	localparam logic [3:0] S_MAG  = 4'd2;
	localparam logic [3:0] S_SQR  = 4'd3;
	localparam logic [3:0] S_ACC  = 4'd4;
	localparam logic [3:0] S_DIV  = 4'd5;
	localparam logic [3:0] S_SQRT = 4'd6;
	localparam logic [3:0] S_GAIN = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	logic [3:0]                state_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [SAMPLE_COUNT_W-1:0] sample_count_q;
	logic [GAIN_W-1:0]         gain_q;
	logic [CHAN_W-1:0]         ch_in_q;
	logic [ADC_BITS-1:0]       samp_q;
	logic [VW-1:0]             off_q [CHANNELS];
	logic [VW-1:0]             mag_q;
	logic [SQ_W-1:0]           sqp_q;
	logic [SUM_W-1:0]          sum_q;
	logic [SEEN_W-1:0]         seen_q;
	logic [RX_W-1:0]           work_q;
	logic [SEEN_W-1:0]         rem_q;
	logic [SEEN_W-1:0]         n_q;
	logic [ROOT_W-1:0]         root_q;
	logic [SR_W-1:0]           srem_q;
	logic [PROD_W-1:0]         gp_q;
	logic                      out_valid_q;
	logic [RMS_W-1:0]          rms_q;
	logic [CHAN_W-1:0]         out_ch_q;

	// Channel tag folded onto the offset filters; a constant lookup.
	logic [CH_W-1:0] chan_map [TAGS];
	for (genvar i = 0; i < TAGS; i++) begin : g_chan_map
		assign chan_map[i] = CH_W'(i % CHANNELS);
	end

	logic [CH_W-1:0]   ch_idx;
	logic [VW-1:0]     sq_val;
	logic [VW-1:0]     off_cur;
	logic [DW-1:0]     diff;
	logic [DW-1:0]     step;
	logic [VW-1:0]     off_new;
	logic [DW-1:0]     filt;
	logic [VW-1:0]     mag;
	logic [VW:0]       sqr_upper;
	logic [SUM_W-1:0]  sum_total;
	logic [SEEN_W-1:0] seen_nx;
	logic [CMP_W-1:0]  target;
	logic              window_done;
	logic [SEEN_W:0]   rem_sh;
	logic              div_ge;
	logic [SR_W+1:0]   sr_sh;
	logic [SR_W+1:0]   sr_trial;
	logic              sr_ge;
	logic [ROOT_W:0]   gain_upper;
	logic              gain_sat;
	logic [RMS_W-1:0]  rms_val;
	logic              out_free;
	logic              cnt_last;
	logic [CNT_W-1:0]  cnt_end;

	assign ch_idx  = chan_map[ch_in_q];
	assign sq_val  = {samp_q, FILT_SHIFT'(0)};
	assign off_cur = off_q[ch_idx];

	// The filter step is an arithmetic shift, which rounds towards minus infinity.
	assign diff    = {1'b0, sq_val} - {1'b0, off_cur};
	assign step    = {{FILT_SHIFT{diff[DW-1]}}, diff[DW-1:FILT_SHIFT]};
	assign off_new = VW'({1'b0, off_cur} + step);

	// In the next state off_cur already holds the updated offset.
	assign filt = {1'b0, sq_val} - {1'b0, off_cur};
	assign mag  = filt[DW-1] ? VW'(DW'(0) - filt) : VW'(filt);

	// Shift-and-add squarer: the multiplier sits in the low half of sqp_q.
	assign sqr_upper = {1'b0, sqp_q[SQ_W-1:VW]} + (sqp_q[0] ? {1'b0, mag_q} : '0);

	assign sum_total = sum_q + SUM_W'(sqp_q);
	assign seen_nx   = seen_q + SEEN_W'(1);

	// A zero length acts as one; an over-long window is clipped.
	always_comb begin
		target = CMP_W'(sample_count_q);
		if (sample_count_q == '0) begin
			target = CMP_W'(1);
		end
		if (target > CMP_W'(MAX_WINDOW)) begin
			target = CMP_W'(MAX_WINDOW);
		end
	end
	assign window_done = CMP_W'(seen_nx) >= target;

	// Restoring divide, one quotient bit per cycle.
	assign rem_sh = {rem_q, work_q[SUM_W-1]};
	assign div_ge = rem_sh >= {1'b0, n_q};

	// Digit-by-digit square root, one bit pair per cycle.
	assign sr_sh    = {srem_q, work_q[RX_W-1 -: 2]};
	assign sr_trial = {1'b0, root_q, 2'b01};
	assign sr_ge    = sr_sh >= sr_trial;

	// Shift-and-add gain multiply: the gain sits in the low bits of gp_q.
	assign gain_upper = {1'b0, gp_q[PROD_W-1:GAIN_W]} + (gp_q[0] ? {1'b0, root_q} : '0);
	assign gain_sat   = |gp_q[PROD_W-1:FILT_SHIFT+RMS_W];
	assign rms_val    = gain_sat ? '1 : gp_q[FILT_SHIFT+RMS_W-1:FILT_SHIFT];

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		case (state_q)
			S_SQR:   cnt_end = CNT_W'(VW - 1);
			S_DIV:   cnt_end = CNT_W'(SUM_W - 1);
			S_SQRT:  cnt_end = CNT_W'(ROOT_W - 1);
			S_GAIN:  cnt_end = CNT_W'(GAIN_W - 1);
			default: cnt_end = '0;
		endcase
	end
	assign cnt_last = cnt_q == cnt_end;

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(rms_q);
	assign m_tuser  = out_ch_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SAMPLE_COUNT_RST;
			gain_q         <= GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_COUNT: sample_count_q <= cfg_data[SAMPLE_COUNT_W-1:0];
				REG_GAIN:         gain_q         <= cfg_data[GAIN_W-1:0];
				default:          ;
			endcase
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sum_q       <= '0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				off_q[c] <= OFFSET_RST;
			end
		end else begin
			// A new result may replace one that leaves in the same cycle.
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_FILT;
					end
				end
				S_FILT: begin
					off_q[ch_idx] <= off_new;
					state_q       <= S_MAG;
				end
				S_MAG: begin
					cnt_q   <= '0;
					state_q <= S_SQR;
				end
				S_SQR: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_last) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					cnt_q <= '0;
					if (window_done) begin
						sum_q   <= '0;
						seen_q  <= '0;
						state_q <= S_DIV;
					end else begin
						sum_q   <= sum_total;
						seen_q  <= seen_nx;
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= S_SQRT;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_SQRT: begin
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= S_GAIN;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_GAIN: begin
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= S_OUT;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Serial datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ch_in_q <= s_tuser;
				samp_q  <= s_tdata[ADC_BITS-1:0];
			end
			S_MAG: begin
				mag_q <= mag;
				sqp_q <= SQ_W'(mag);
			end
			S_SQR: begin
				sqp_q <= {sqr_upper, sqp_q[VW-1:1]};
			end
			S_ACC: begin
				work_q <= RX_W'(sum_total);
				n_q    <= seen_nx;
				rem_q  <= '0;
				srem_q <= '0;
				root_q <= '0;
				gp_q   <= PROD_W'(gain_q);
			end
			S_DIV: begin
				rem_q                <= div_ge ? SEEN_W'(rem_sh - {1'b0, n_q}) : SEEN_W'(rem_sh);
				work_q[SUM_W-1:0]    <= {work_q[SUM_W-2:0], div_ge};
			end
			S_SQRT: begin
				srem_q <= sr_ge ? SR_W'(sr_sh - sr_trial) : SR_W'(sr_sh);
				root_q <= {root_q[ROOT_W-2:0], sr_ge};
				work_q <= {work_q[RX_W-3:0], 2'b00};
			end
			S_GAIN: begin
				gp_q <= {gain_upper, gp_q[GAIN_W-1:1]};
			end
			S_OUT: begin
				if (out_free) begin
					rms_q    <= rms_val;
					out_ch_q <= ch_in_q;
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	// An accepted sample always starts the offset update in the next cycle.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_FILT))
		else $error("accepted sample did not start the filter update");

	// The window counter never runs past the longest window.
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(seen_q) < CMP_W'(MAX_WINDOW))
		else $error("window counter exceeded the maximum window");

	// The divide remainder stays below the divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < n_q))
		else $error("divide remainder not below divisor");

	// The square root remainder never exceeds twice the partial root.
	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQRT) |-> (srem_q <= {root_q, 1'b0}))
		else $error("square root remainder out of range");
`endif

endmodule

@@ dv/mrms_reading_checker.sv @@
// ----------------------------------------------------------------------------
// mrms_reading_checker - result checker for the RMS current meter core
// Watches the sample, result and configuration ports, keeps its own copy of
// the per-channel offset filters and the window sum, and compares every
// reading that leaves the core with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mrms_reading_checker
	import mrms_pkg::*;
#(
	parameter int S_TDATA_W = ((ADC_BITS_DEF+7)/8)*8,
	parameter int M_TDATA_W = ((RMS_W+7)/8)*8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	input  logic [CHAN_W-1:0]     s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_TDATA_W-1:0]  m_tdata,
	input  logic [CHAN_W-1:0]     m_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatch_total,
	output int                    readings_outstanding
);

	typedef longint unsigned u64_t;

	localparam int   OFFSET_W    = 2*ADC_BITS_DEF;
	localparam u64_t RMS_LIMIT   = (u64_t'(1) << RMS_W) - 1;
	localparam int   OFFSET_MID  = 1 << (ADC_BITS_DEF - 1 + FILT_SHIFT);

	typedef struct packed {
		logic [RMS_W-1:0]  rms_ma;
		logic [CHAN_W-1:0] window_channel;
	} reading_t;

	logic [OFFSET_W-1:0]       dc_offset_q [CHANNELS_DEF];
	u64_t                      square_total = 0;
	int unsigned               window_fill = 0;
	logic [SAMPLE_COUNT_W-1:0] window_len_reg = SAMPLE_COUNT_RST;
	logic [GAIN_W-1:0]         gain_reg = GAIN_RST;
	reading_t                  awaited_readings [$];
	reading_t                  head_reading;

	task automatic flag_mismatch(input string what);
		$display("[%0t] reading mismatch: %s", $realtime, what);
		mismatch_total++;
	endtask

	// Largest root whose square does not exceed v, built one bit at a time.
	function automatic u64_t floor_sqrt(input u64_t v);
		u64_t root;
		u64_t trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (u64_t'(1) << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	// Runs one sample through the channel's offset filter and the window sum,
	// and queues a reading when the window closes.
	task automatic fold_sample(input logic [CHAN_W-1:0] ch, input logic [ADC_BITS_DEF-1:0] smp);
		longint      sample_q;
		longint      drift;
		longint      centred;
		u64_t        mean;
		u64_t        scaled;
		int unsigned limit;
		reading_t    fresh;
		sample_q = longint'(smp) << FILT_SHIFT;
		drift = sample_q - longint'(dc_offset_q[ch]);
		// The arithmetic shift floors, so negative steps round downwards.
		dc_offset_q[ch] = OFFSET_W'(longint'(dc_offset_q[ch]) + (drift >>> FILT_SHIFT));
		centred = sample_q - longint'(dc_offset_q[ch]);
		square_total = square_total + u64_t'(centred * centred);
		window_fill++;
		if (window_len_reg == 0)
			limit = 1;
		else if (window_len_reg > MAX_WINDOW_DEF)
			limit = MAX_WINDOW_DEF;
		else
			limit = window_len_reg;
		if (window_fill >= limit) begin
			mean = square_total / window_fill;
			scaled = (u64_t'(gain_reg) * floor_sqrt(mean)) >> FILT_SHIFT;
			if (scaled > RMS_LIMIT)
				scaled = RMS_LIMIT;
			fresh.rms_ma = RMS_W'(scaled);
			fresh.window_channel = ch;
			awaited_readings.push_back(fresh);
			square_total = 0;
			window_fill = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS_DEF; c++)
				dc_offset_q[c] = OFFSET_W'(OFFSET_MID);
			square_total = 0;
			window_fill = 0;
			window_len_reg = SAMPLE_COUNT_RST;
			gain_reg = GAIN_RST;
			awaited_readings.delete();
			readings_outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_readings.size() == 0) begin
					flag_mismatch($sformatf("unexpected reading rms_ma=%0d channel=%0d",
						m_tdata[RMS_W-1:0], m_tuser));
				end else begin
					head_reading = awaited_readings.pop_front();
					if (m_tdata[RMS_W-1:0] !== head_reading.rms_ma ||
							m_tuser !== head_reading.window_channel)
						flag_mismatch($sformatf("rms_ma=%0d want %0d, channel=%0d want %0d",
							m_tdata[RMS_W-1:0], head_reading.rms_ma,
							m_tuser, head_reading.window_channel));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SAMPLE_COUNT: window_len_reg = cfg_data[SAMPLE_COUNT_W-1:0];
					REG_GAIN:         gain_reg = cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				fold_sample(s_tuser, s_tdata[ADC_BITS_DEF-1:0]);
			readings_outstanding <= awaited_readings.size();
		end
	end

endmodule

@@ dv/multichannel_rms_current_meter_core_test.sv @@
// ----------------------------------------------------------------------------
// multichannel_rms_current_meter_core_test - top of the RMS meter testbench
// Drives sample requests and configuration writes into the core, throttles
// the result side, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module multichannel_rms_current_meter_core_test;
	import mrms_pkg::*;

	localparam int S_TDATA_W     = ((ADC_BITS_DEF+7)/8)*8;
	localparam int M_TDATA_W     = ((RMS_W+7)/8)*8;
	localparam int PAD_W         = S_TDATA_W - ADC_BITS_DEF;
	localparam int CNT_HIGH_W    = CFG_DATA_W - SAMPLE_COUNT_W;
	// A closing sample keeps the core busy through the squaring, the divide, the square root and the gain multiply.
	localparam int SETTLE_CYCLES = 160;
	localparam int LONG_HOLD     = 2000;
	localparam int RANDOM_ITEMS  = 120;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [CHAN_W-1:0]     s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [CHAN_W-1:0]     m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_SAMPLE_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatch_total;
	int readings_outstanding;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	// Bumping this token asks the receiver for one long hold-off.
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;

	always #10 clk = ~clk;

	multichannel_rms_current_meter_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // [9:0] sample, [15:10] padding
		.s_tuser   (s_tuser),    // [1:0] channel
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),    // [25:0] rms_ma
		.m_tuser   (m_tuser),    // [1:0] window_channel
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mrms_reading_checker u_checker (
		.clk                  (clk),
		.arst_n               (arst_n),
		.s_tvalid             (s_tvalid),
		.s_tready             (s_tready),
		.s_tdata              (s_tdata),
		.s_tuser              (s_tuser),
		.m_tvalid             (m_tvalid),
		.m_tready             (m_tready),
		.m_tdata              (m_tdata),
		.m_tuser              (m_tuser),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.mismatch_total       (mismatch_total),
		.readings_outstanding (readings_outstanding)
	);

	// Result side. A long hold-off is counted here, in its own process, so
	// that the sender carries on offering requests while the core fills up.
	// Otherwise the receiver stalls at random at the current percentage.
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offers one sample request and returns at the edge where it is taken.
	// Valid stays high on return, so that a following request can go out
	// back to back; the caller lowers it when the stream is to pause.
	task automatic offer_sample(input logic [CHAN_W-1:0] ch,
			input logic [ADC_BITS_DEF-1:0] smp, input logic [PAD_W-1:0] pad);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {pad, smp};
		s_tuser <= ch;
		do @(posedge clk); while (!s_tready);
	endtask

	// Random sample: mostly anywhere in the ADC range, now and then at either
	// rail, and with junk in the padding bits above the sample in some cases.
	task automatic offer_random_sample();
		logic [CHAN_W-1:0]       ch;
		logic [ADC_BITS_DEF-1:0] smp;
		logic [PAD_W-1:0]        pad;
		ch = CHAN_W'($urandom_range(CHANNELS_DEF - 1));
		case ($urandom_range(7))
			0:       smp = '0;
			1:       smp = '1;
			default: smp = ADC_BITS_DEF'($urandom);
		endcase
		pad = ($urandom_range(3) == 0) ? PAD_W'($urandom) : '0;
		offer_sample(ch, smp, pad);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Stops the sample stream until every predicted reading has left the core.
	task automatic wait_readings_clear();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (readings_outstanding != 0);
	endtask

	// A sample that closes no window may still be in flight once the last
	// reading is out, so the core gets its full latency before any write.
	task automatic drain_and_settle();
		wait_readings_clear();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One idling mode: a series of random settings, each followed by a burst
	// of random samples. Short windows keep readings frequent, and bursts that
	// stop part way through a window exercise a window shortened mid-way once
	// the next setting is written.
	task automatic run_random_phase(input int gap_pct, input int stall_pct, input bit with_pause);
		int                  sent;
		int                  burst;
		int                  pause_at;
		int                  cnt;
		logic [GAIN_W-1:0]   gain_val;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain_and_settle();
			case ($urandom_range(9))
				0:       cnt = 0;
				1:       cnt = $urandom_range(13, 48);
				default: cnt = $urandom_range(1, 12);
			endcase
			// The bits above the register width are set at random; the core
			// must drop them.
			write_reg(REG_SAMPLE_COUNT, {CNT_HIGH_W'($urandom), SAMPLE_COUNT_W'(cnt)});
			case ($urandom_range(5))
				0:       gain_val = '0;
				1:       gain_val = '1;
				default: gain_val = GAIN_W'($urandom);
			endcase
			write_reg(REG_GAIN, gain_val);
			burst = $urandom_range(20, 60);
			pause_at = with_pause ? $urandom_range(5, burst - 1) : -1;
			for (int i = 0; i < burst; i++) begin
				if (i == pause_at)
					wait_readings_clear();
				offer_random_sample();
			end
			sent += burst;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: a 400 sample window at the default gain. The first
		// twenty requests walk every channel through both rails, mid-scale
		// and a full swing with the padding bits set; the rest are random.
		for (int i = 0; i < 20; i++) begin
			case (i / 4)
				0: offer_sample(CHAN_W'(i), '0, '0);
				1: offer_sample(CHAN_W'(i), '1, '0);
				2: offer_sample(CHAN_W'(i), ADC_BITS_DEF'(512), '0);
				3: offer_sample(CHAN_W'(i), ADC_BITS_DEF'(511), '1);
				default: offer_sample(CHAN_W'(i), (i % 2) ? '1 : '0, '1);
			endcase
		end
		for (int i = 20; i < 400; i++)
			offer_random_sample();
		drain_and_settle();

		// A window length of zero behaves as one, here at full gain.
		write_reg(REG_SAMPLE_COUNT, '0);
		write_reg(REG_GAIN, '1);
		for (int i = 0; i < 8; i++)
			offer_sample(CHAN_W'(i), (i % 2) ? '1 : '0, '0);
		drain_and_settle();

		// Only the low register bits count: this asks for a window of three,
		// and a gain of zero must give zero readings.
		write_reg(REG_SAMPLE_COUNT, 16'hE003);
		write_reg(REG_GAIN, '0);
		for (int i = 0; i < 6; i++)
			offer_sample(CHAN_W'(3 - i % 4), (i % 3 == 0) ? '1 : ADC_BITS_DEF'(i * 100), '0);
		drain_and_settle();

		// Window shortened part way: seven samples into a window of ten, the
		// length drops to four, so the next sample closes a window of eight.
		write_reg(REG_SAMPLE_COUNT, 16'd10);
		write_reg(REG_GAIN, 16'd1000);
		for (int i = 0; i < 7; i++)
			offer_sample(CHAN_W'(i), ADC_BITS_DEF'(i * 150), '0);
		drain_and_settle();
		write_reg(REG_SAMPLE_COUNT, 16'd4);
		offer_sample(CHAN_W'(2), '1, '0);
		drain_and_settle();

		// A length above the largest window is held at the largest window, so
		// a hundred rail to rail samples close nothing; shortening the window
		// to one then closes a window of a hundred and one at full gain.
		write_reg(REG_SAMPLE_COUNT, 16'h1FFF);
		write_reg(REG_GAIN, '1);
		for (int i = 0; i < 100; i++)
			offer_sample(CHAN_W'($urandom), (i % 2) ? '1 : '0, '0);
		drain_and_settle();
		write_reg(REG_SAMPLE_COUNT, 16'd1);
		offer_sample(CHAN_W'(1), '1, '0);
		drain_and_settle();

		// Every sample closes a window while the receiver holds off for a long
		// stretch: the output register fills and the core stalls its input.
		write_reg(REG_SAMPLE_COUNT, 16'd1);
		write_reg(REG_GAIN, GAIN_W'($urandom));
		hold_token++;
		for (int i = 0; i < 40; i++)
			offer_random_sample();
		drain_and_settle();

		run_random_phase(0, 0, 1'b0);
		run_random_phase(49, 0, 1'b1);
		run_random_phase(0, 49, 1'b0);
		run_random_phase(34, 34, 1'b1);
		drain_and_settle();

		if (mismatch_total == 0)
			$display("multichannel_rms_current_meter_core_test: done, clean");
		else
			$display("multichannel_rms_current_meter_core_test: done, errors");
		$finish;
	end

	// Guard against a hung core: far beyond the slowest correct run.
	initial begin
		#30000000;
		$display("multichannel_rms_current_meter_core_test: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/mrms_pkg.sv
rtl/core/multichannel_rms_current_meter_core.sv
dv/mrms_reading_checker.sv
dv/multichannel_rms_current_meter_core_test.sv
